/* rtl/mtf_pkg.sv */
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared widths and the control bundle sent from the top level to the cells.
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int VAL_W  = 8;   // input value and result width
    localparam int SIZE_W = 9;   // table size register width
    localparam int SYM_W  = 9;   // a list entry holds up to table_size-1

    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [VAL_W-1:0]  val_t;

    // One bundle broadcast to every cell of the chain
    typedef struct packed {
        logic  init;     // reload the descending list
        size_t size;     // table size in force (new size during init)
        logic  capture;  // item accepted: latch the match flag
        logic  in_err;   // accepted item is out of range
        logic  mode;     // 0 encode, 1 decode
        val_t  value;    // symbol or rank of the accepted item
        logic  shift;    // move the hit symbol to the front
    } cell_ctrl_t;

endpackage

/* rtl/mtf_cell.sv */
// ----------------------------------------------------------------------------
// mtf_cell
// One list position: holds a symbol, compares it (its index when decoding)
// with the item, takes its left neighbour's symbol when the hit moves to front.
// ----------------------------------------------------------------------------
module mtf_cell
    import mtf_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 8,
    parameter int DEF_SIZE = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [IDX_W-1:0] hit_pos,
    input  sym_t             left_sym,
    output sym_t             sym,
    output logic             match
);

    localparam sym_t RESET_SYM    = (CELL_IDX < DEF_SIZE) ? sym_t'(DEF_SIZE - 1 - CELL_IDX)
                                                          : '0;
    localparam bit   FITS_SIZE    = CELL_IDX < 511;
    localparam bit   FITS_VAL     = CELL_IDX < 256;
    localparam sym_t IDX_SYM      = sym_t'(CELL_IDX);
    localparam sym_t IDX_SYM_NEXT = sym_t'(CELL_IDX + 1);

    sym_t sym_reg;
    sym_t sym_next;
    logic match_reg;
    logic match_next;
    logic in_use;
    logic hit_here;
    logic shift_here;

    always_comb
    begin
        in_use     = FITS_SIZE && (ctrl.size > IDX_SYM);
        hit_here   = in_use && (ctrl.mode ? (FITS_VAL && ctrl.value == VAL_W'(CELL_IDX))
                                          : (sym_reg == {1'b0, ctrl.value}));
        shift_here = ctrl.shift && (IDX_W'(CELL_IDX) <= hit_pos);

        sym_next = sym_reg;
        if (ctrl.init)
        begin
            sym_next = in_use ? (ctrl.size - IDX_SYM_NEXT) : '0;
        end
        else if (shift_here)
        begin
            sym_next = left_sym;
        end

        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = !ctrl.in_err && hit_here;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg   <= RESET_SYM;
            match_reg <= 1'b0;
        end
        else
        begin
            sym_reg   <= sym_next;
            match_reg <= match_next;
        end
    end

    assign sym   = sym_reg;
    assign match = match_reg;

endmodule

/* rtl/mtf_reduce.sv */
// ----------------------------------------------------------------------------
// mtf_reduce
// Two-level registered OR tree: finds the position and symbol of the one
// cell whose match flag is set.
// ----------------------------------------------------------------------------
module mtf_reduce
    import mtf_pkg::*;
#(
    parameter int N     = 256,
    parameter int IDX_W = 8
)
(
    input  logic             clk,
    input  logic [N-1:0]     match,
    input  sym_t             sym [N],
    output logic             hit_any,
    output logic [IDX_W-1:0] hit_pos,
    output sym_t             hit_sym
);

    localparam int GROUP = 16;
    localparam int NGRP  = (N + GROUP - 1) / GROUP;

    logic             grp_any_reg [NGRP];
    logic [IDX_W-1:0] grp_pos_reg [NGRP];
    sym_t             grp_sym_reg [NGRP];
    logic             grp_any_next [NGRP];
    logic [IDX_W-1:0] grp_pos_next [NGRP];
    sym_t             grp_sym_next [NGRP];

    logic             hit_any_reg;
    logic [IDX_W-1:0] hit_pos_reg;
    sym_t             hit_sym_reg;
    logic             hit_any_next;
    logic [IDX_W-1:0] hit_pos_next;
    sym_t             hit_sym_next;

    // First level: OR within each group of sixteen cells
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_pos_next[g] = '0;
            grp_sym_next[g] = '0;
            for (int e = 0; e < GROUP; e++)
            begin
                if (g * GROUP + e < N)
                begin
                    if (match[g * GROUP + e])
                    begin
                        grp_any_next[g] = 1'b1;
                        grp_pos_next[g] = grp_pos_next[g] | IDX_W'(g * GROUP + e);
                        grp_sym_next[g] = grp_sym_next[g] | sym[g * GROUP + e];
                    end
                end
            end
        end
    end

    // Second level: OR across the groups
    always_comb
    begin
        hit_any_next = 1'b0;
        hit_pos_next = '0;
        hit_sym_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            hit_any_next = hit_any_next | grp_any_reg[g];
            hit_pos_next = hit_pos_next | grp_pos_reg[g];
            hit_sym_next = hit_sym_next | grp_sym_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_reg[g] <= grp_any_next[g];
            grp_pos_reg[g] <= grp_pos_next[g];
            grp_sym_reg[g] <= grp_sym_next[g];
        end
        hit_any_reg <= hit_any_next;
        hit_pos_reg <= hit_pos_next;
        hit_sym_reg <= hit_sym_next;
    end

    assign hit_any = hit_any_reg;
    assign hit_pos = hit_pos_reg;
    assign hit_sym = hit_sym_reg;

endmodule

/* rtl/move_to_front_coder.sv */
// ----------------------------------------------------------------------------
// move_to_front_coder
// Move-to-front encoder/decoder built as a chain of list cells.
//
// Usage:
//   Input channel item_valid/item_ready carries mode (0 encode, 1 decode)
//   and value (symbol or rank). Output channel res_valid/res_ready carries
//   result (rank or symbol, 0 on error) and error (value not below size).
//   cfg_we/cfg_data write the table size; 0 means 256, larger values are
//   capped at MAX_SYMBOLS. A write reloads the list in the same cycle and
//   must only be issued while no item is in flight.
//   On acceptance the cells latch their match flags, a two-level registered
//   OR tree finds the hit position and symbol, then the chain shifts while
//   the result is loaded. One item is in flight at a time, so no new item
//   is taken until that result has been loaded.
//   After reset the list holds min(256, MAX_SYMBOLS) symbols in descending
//   order. When the receiver stalls, a finished item waits in the final
//   step with the list not yet shifted until the output register frees.
// ----------------------------------------------------------------------------
module move_to_front_coder
    import mtf_pkg::*;
#(
    parameter int MAX_SYMBOLS = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              mode,
    input  logic [VAL_W-1:0]  value,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [VAL_W-1:0]  result,
    output logic              error,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_data
);

    localparam int    IDX_W    = $clog2(MAX_SYMBOLS);
    localparam int    DEF_SIZE = (MAX_SYMBOLS < 256) ? MAX_SYMBOLS : 256;
    localparam size_t SIZE_CAP = (MAX_SYMBOLS > 511) ? size_t'(511) : size_t'(MAX_SYMBOLS);
    localparam size_t SIZE_ZERO_AS = size_t'(256);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RED1,
        S_RED2,
        S_DONE
    } state_t;

    state_t     state_reg;
    logic       mode_reg;
    logic       err_reg;
    size_t      size_reg;
    logic       res_valid_reg;
    val_t       result_reg;
    logic       error_reg;

    logic       accept;
    logic       in_err;
    logic       out_free;
    logic       finish;
    size_t      size_wr;
    size_t      size_raw;
    cell_ctrl_t ctrl;

    logic [MAX_SYMBOLS-1:0] cell_match;
    sym_t                   cell_sym [MAX_SYMBOLS];
    logic                   hit_any;
    logic [IDX_W-1:0]       hit_pos;
    sym_t                   hit_sym;
    logic                   fail;
    val_t                   result_next;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign in_err     = ({1'b0, value} >= size_reg);
    assign out_free   = !res_valid_reg || res_ready;
    assign finish     = (state_reg == S_DONE) && out_free;

    // Size write: zero stands for 256, then cap at the list length
    always_comb
    begin
        size_raw = (cfg_data == '0) ? SIZE_ZERO_AS : cfg_data;
        size_wr  = (size_raw > SIZE_CAP) ? SIZE_CAP : size_raw;
    end

    always_comb
    begin
        ctrl.init    = cfg_we;
        ctrl.size    = cfg_we ? size_wr : size_reg;
        ctrl.capture = accept;
        ctrl.in_err  = in_err;
        ctrl.mode    = mode;
        ctrl.value   = value;
        ctrl.shift   = finish && !err_reg && hit_any;
    end

    for (genvar i = 0; i < MAX_SYMBOLS; i++)
    begin : g_cell
        sym_t left_sym;
        if (i == 0)
        begin : g_front
            assign left_sym = hit_sym;
        end
        else
        begin : g_rest
            assign left_sym = cell_sym[i-1];
        end

        mtf_cell #(
            .CELL_IDX (i),
            .IDX_W    (IDX_W),
            .DEF_SIZE (DEF_SIZE)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .hit_pos  (hit_pos),
            .left_sym (left_sym),
            .sym      (cell_sym[i]),
            .match    (cell_match[i])
        );
    end

    mtf_reduce #(
        .N     (MAX_SYMBOLS),
        .IDX_W (IDX_W)
    ) u_reduce (
        .clk     (clk),
        .match   (cell_match),
        .sym     (cell_sym),
        .hit_any (hit_any),
        .hit_pos (hit_pos),
        .hit_sym (hit_sym)
    );

    assign fail        = err_reg || !hit_any;
    assign result_next = fail ? '0 : (mode_reg ? hit_sym[VAL_W-1:0] : VAL_W'(hit_pos));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b0;
            err_reg       <= 1'b0;
            size_reg      <= size_t'(DEF_SIZE);
            res_valid_reg <= 1'b0;
            result_reg    <= '0;
            error_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= size_wr;
            end
            if (res_valid_reg && res_ready && !finish)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg  <= mode;
                        err_reg   <= in_err;
                        state_reg <= S_RED1;
                    end
                end
                S_RED1:
                begin
                    state_reg <= S_RED2;
                end
                S_RED2:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register frees
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        result_reg    <= result_next;
                        error_reg     <= fail;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign result    = result_reg;
    assign error     = error_reg;

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED1) |-> $onehot0(cell_match))
        else $error("more than one cell matched the item");

    a_inrange_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !err_reg) |-> hit_any)
        else $error("in-range item found no cell");

    a_item_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 (state_reg == S_RED2))
        else $error("accepted item did not reach the reduction stage");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the final step");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && error_reg) |-> (result_reg == '0))
        else $error("errored item carries a non-zero result");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the move-to-front coder. Items go in over the
// valid/ready input channel and each result is checked against a local
// move-to-front list kept in step with every accepted item. Directed items
// cover the list ends, the front symbol, out-of-range values and the
// table size writes (one, two, zero for full, above full). Random phases at
// random sizes follow, then a long receiver hold and a final stretch
// with no idling on either side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtf_pkg::*;

    localparam int MAX_SYMBOLS = 256;
    localparam int STALL_LIMIT = 3000;  // quiet cycles before giving up
    localparam int HOLD_CYCLES = 200;   // long receiver hold-off
    localparam int TAIL_CYCLES = 20;    // watch for stray results at the end

    typedef enum logic {ENCODE = 1'b0, DECODE = 1'b1} coder_mode_t;

    typedef struct packed {
        val_t result;
        logic error;
    } code_result_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        mode       = 1'b0;
    val_t        value      = '0;
    logic        res_valid;
    logic        res_ready  = 1'b0;
    val_t        result;
    logic        error;
    logic        cfg_we     = 1'b0;
    size_t       cfg_data   = '0;

    // local copy of the symbol list
    val_t         symbol_order [MAX_SYMBOLS];
    int unsigned  list_len;
    code_result_t awaited_codes [$];

    int   fault_count = 0;
    bit   idling      = 1'b1;
    int   rx_hold_len = 0;

    move_to_front_coder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .mode       (mode),
        .value      (value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .result     (result),
        .error      (error),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Reload the list in descending order for a written size
    function automatic void load_list(input size_t raw);
        int unsigned n;
        int          i;
        n = raw;
        if (n == 0)
            n = 256;
        if (n > MAX_SYMBOLS)
            n = MAX_SYMBOLS;
        list_len = n;
        for (i = 0; i < MAX_SYMBOLS; i++)
            symbol_order[i] = (i < n) ? val_t'(n - 1 - i) : '0;
    endfunction

    function automatic code_result_t move_to_front(input coder_mode_t m, input val_t v);
        code_result_t r;
        int unsigned  pos;
        int unsigned  k;
        val_t         sym;
        bit           found;
        r     = '{result: '0, error: 1'b0};
        found = 1'b0;
        pos   = 0;
        if (v >= list_len)
        begin
            r.error = 1'b1;
            return r;
        end
        if (m == ENCODE)
        begin
            while (!found && pos < list_len)
            begin
                if (symbol_order[pos] == v)
                    found = 1'b1;
                else
                    pos++;
            end
            if (!found)
            begin
                r.error = 1'b1;
                return r;
            end
        end
        else
            pos = v;
        sym      = symbol_order[pos];
        r.result = (m == ENCODE) ? val_t'(pos) : sym;
        for (k = pos; k > 0; k--)
            symbol_order[k] = symbol_order[k - 1];
        symbol_order[0] = sym;
        return r;
    endfunction

    task automatic send_item(input coder_mode_t m, input val_t v);
        int gap;
        gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        mode       <= m;
        value      <= v;
        do
            @(posedge clk);
        while (!item_ready);
        awaited_codes.push_back(move_to_front(m, v));
    endtask

    // Drop valid and hold until every outstanding result has been taken
    task automatic await_all_codes();
        @(negedge clk);
        item_valid <= 1'b0;
        while (awaited_codes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_table_size(input size_t raw);
        await_all_codes();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= raw;
        @(negedge clk);
        cfg_we   <= 1'b0;
        load_list(raw);
    endtask

    task automatic send_random(input int count, input int bad_pct);
        coder_mode_t m;
        val_t        v;
        int          i;
        int unsigned span;
        for (i = 0; i < count; i++)
        begin
            m    = coder_mode_t'($urandom_range(0, 1));
            span = (list_len < 8) ? list_len - 1 : 7;
            if (list_len < MAX_SYMBOLS && $urandom_range(0, 99) < bad_pct)
                v = val_t'($urandom_range(list_len, MAX_SYMBOLS - 1));
            else if ($urandom_range(0, 3) == 0)
                v = val_t'($urandom_range(0, span));  // favour the front of the list
            else
                v = val_t'($urandom_range(0, list_len - 1));
            send_item(m, v);
        end
    endtask

    task automatic test_reset_list();
        send_item(ENCODE, 8'd255);   // already at the front
        send_item(ENCODE, 8'd0);     // from the back
        send_item(ENCODE, 8'd0);
        send_item(DECODE, 8'd255);
        send_item(DECODE, 8'd0);
        send_item(ENCODE, 8'd128);
        send_item(DECODE, 8'd1);
        send_item(DECODE, 8'd170);
        await_all_codes();
    endtask

    task automatic test_size_extremes();
        write_table_size(9'd1);
        send_item(ENCODE, 8'd0);
        send_item(DECODE, 8'd0);
        send_item(ENCODE, 8'd1);
        send_item(DECODE, 8'd255);
        send_item(ENCODE, 8'd255);
        write_table_size(9'd2);
        send_item(DECODE, 8'd1);
        send_item(ENCODE, 8'd1);
        send_item(DECODE, 8'd2);
        write_table_size(9'd0);      // zero means full size
        send_item(ENCODE, 8'd0);
        send_item(DECODE, 8'd255);
        write_table_size(9'd511);    // capped at full size
        send_item(ENCODE, 8'd1);
        write_table_size(9'd257);
        send_item(DECODE, 8'd128);
        await_all_codes();
    endtask

    task automatic test_random_sizes();
        int    p;
        size_t raw;
        for (p = 0; p < 10; p++)
        begin
            case ($urandom_range(0, 5))
                0:       raw = size_t'($urandom_range(1, 8));
                1:       raw = size_t'($urandom_range(9, 64));
                2:       raw = size_t'($urandom_range(65, 255));
                3:       raw = 9'd256;
                4:       raw = size_t'($urandom_range(257, 511));
                default: raw = '0;
            endcase
            write_table_size(raw);
            send_random(100, 10);
        end
        await_all_codes();
    endtask

    // Stall the output for a long stretch while items keep coming
    task automatic test_back_pressure();
        idling = 1'b0;
        write_table_size(size_t'($urandom_range(3, 40)));
        rx_hold_len = HOLD_CYCLES;
        send_random(50, 10);
        await_all_codes();
        idling = 1'b1;
    endtask

    task automatic test_steady_stream();
        idling = 1'b0;
        write_table_size(9'd256);
        send_random(150, 0);
        write_table_size(size_t'($urandom_range(1, 255)));
        send_random(150, 10);
        await_all_codes();
    endtask

    // Receiver: random hold-off bursts, plus one long hold on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                res_ready <= 1'b0;
                repeat (rx_hold_len) @(negedge clk);
                rx_hold_len = 0;
                res_ready <= 1'b1;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                res_ready <= 1'b1;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // Check each result against the oldest expectation
    initial
    begin
        code_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready)
            begin
                if (awaited_codes.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: unexpected result %0d error %0b", $time, result, error);
                end
                else
                begin
                    want = awaited_codes.pop_front();
                    if (result !== want.result || error !== want.error)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("%0t: expected result %0d error %0b, got result %0d error %0b",
                                     $time, want.result, want.error, result, error);
                    end
                end
            end
        end
    end

    // Watchdog: give up after too long with no handshake on either side
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** move_to_front_coder: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        load_list(9'd256);
        test_reset_list();
        test_size_extremes();
        test_random_sizes();
        test_back_pressure();
        test_steady_stream();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && awaited_codes.size() == 0)
            $display("** move_to_front_coder: PASSED **");
        else
            $display("** move_to_front_coder: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/mtf_pkg.sv
rtl/mtf_cell.sv
rtl/mtf_reduce.sv
rtl/move_to_front_coder.sv
test/tb.sv
